// ===== design/vario_tone_mapper_top_macros.svh =====
`ifndef VARIO_TONE_MAPPER_TOP_MACROS_SVH
`define VARIO_TONE_MAPPER_TOP_MACROS_SVH
// same-cycle implication check
`define VTM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vtm assertion failed");
// next-cycle implication check
`define VTM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vtm assertion failed");
`endif

// ===== design/vtm_pkg.sv =====
`default_nettype none
package vtm_pkg;
  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int NUM_W = 27;
  localparam int DEN_W = 13;

  localparam logic [1:0] CLS_SILENT = 2'd0;
  localparam logic [1:0] CLS_SINK   = 2'd1;
  localparam logic [1:0] CLS_CLIMB  = 2'd2;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [2:0] REG_SINK  = 3'd0;
  localparam logic [2:0] REG_CLIMB = 3'd1;
  localparam logic [2:0] REG_SENS  = 3'd2;
  localparam logic [2:0] REG_VOL   = 3'd3;
  localparam logic [2:0] REG_TSIZE = 3'd4;

  // x / 100 == (x * PCT_RECIP) >> PCT_SHIFT for x below 2^20
  localparam int PCT_SHIFT = 26;
  localparam logic [19:0] PCT_RECIP = 20'd671089;

  typedef struct packed {
    logic signed [11:0] vel;
    logic [12:0] freq;
    logic [11:0] period;
    logic [6:0]  duty;
  } entry_t;

  typedef struct packed {
    logic start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [NUM_W-1:0] quo;
    logic [DEN_W-1:0] rem;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== design/vtm_if.sv =====
`default_nettype none
interface vtm_in_if;
  logic valid;
  logic ready;
  logic req_type;
  logic [3:0] table_index;
  logic signed [11:0] entry_velocity;
  logic [12:0] entry_freq;
  logic [11:0] entry_period;
  logic [6:0] entry_duty;
  logic signed [11:0] velocity;
  modport source (output valid, req_type, table_index, entry_velocity, entry_freq,
                  entry_period, entry_duty, velocity, input ready);
  modport sink (input valid, req_type, table_index, entry_velocity, entry_freq,
                entry_period, entry_duty, velocity, output ready);
endinterface

interface vtm_out_if;
  logic valid;
  logic ready;
  logic tone_on;
  logic [1:0] beep_class;
  logic [12:0] tone_freq;
  logic [11:0] beep_period;
  logic [11:0] beep_on_time;
  logic [6:0] beep_volume;
  modport source (output valid, tone_on, beep_class, tone_freq, beep_period,
                  beep_on_time, beep_volume, input ready);
  modport sink (input valid, tone_on, beep_class, tone_freq, beep_period,
                beep_on_time, beep_volume, output ready);
endinterface

interface vtm_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [11:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/vario_tone_mapper_top.sv =====
// A table write is taken on accept; a silent sample goes straight to the done state, which raises its word.
// A toned sample reads table entries in turn, each read then checked (1-16 entries), then runs the
// three interpolations (27-step serial divide) when it falls between two entries, then computes
// the on-time and raises its word; a stalled output holds the done state.
// One item is in work at a time; input is ready again as the word is raised.
// Reset (rst, synchronous): class silent, registers to their defaults, table undefined.
`default_nettype none
`include "vario_tone_mapper_top_macros.svh"
module vario_tone_mapper_top import vtm_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  vtm_in_if.sink in_ch,
  vtm_out_if.source out_ch,
  vtm_cfg_if.sink cfg_ch
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_DIVS = 4'd4;
  localparam logic [3:0] S_DIVW = 4'd5;
  localparam logic [3:0] S_DONE = 4'd6;

  localparam logic [1:0] F_FREQ = 2'd0;
  localparam logic [1:0] F_PER  = 2'd1;
  localparam logic [1:0] F_DUTY = 2'd2;
  localparam logic [1:0] F_ONT  = 2'd3;

  logic [3:0] st;
  logic [1:0] cls;
  logic signed [11:0] sink_th, climb_th;
  logic [9:0] sens;
  logic [6:0] vol;
  logic [4:0] tsize;

  logic signed [11:0] v_r;
  logic [IDX_W-1:0] idx, last;
  entry_t ea, re;
  logic [1:0] fld;
  logic signed [27:0] prod;
  logic [12:0] fr;
  logic [11:0] pr, ot;
  logic [6:0] du;

  logic we;
  logic [IDX_W-1:0] waddr;
  entry_t wentry;
  logic [$bits(entry_t)-1:0] rdata;

  div_req_t dreq;
  div_rsp_t drsp;

  // ram and divider
  vtm_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wentry), .raddr(idx), .rdata(rdata)
  );
  assign re = entry_t'(rdata);

  vtm_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign in_ch.ready = (st == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  logic in_acc;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign we = in_acc && (in_ch.req_type == REQ_WRITE) &&
              ({28'd0, in_ch.table_index} < 32'(TABLE_ENTRIES));
  assign waddr = IDX_W'(in_ch.table_index);
  assign wentry = '{vel: in_ch.entry_velocity, freq: in_ch.entry_freq,
                    period: in_ch.entry_period, duty: in_ch.entry_duty};

  always_comb begin
    if (tsize == 5'd0) begin
      last = '0;
    end else if ({27'd0, tsize} > 32'(TABLE_ENTRIES)) begin
      last = IDX_W'(TABLE_ENTRIES - 1);
    end else begin
      last = IDX_W'(tsize - 5'd1);
    end
  end

  // class update
  logic signed [13:0] vin, sink_hi, climb_lo;
  logic chg;
  logic [1:0] cls_next;
  always_comb begin
    vin = 14'(in_ch.velocity);
    sink_hi = 14'(sink_th) + 14'(sens);
    climb_lo = 14'(climb_th) - 14'(sens);
    case (cls)
      CLS_SINK:  chg = sink_hi < vin;
      CLS_CLIMB: chg = vin < climb_lo;
      default:   chg = (vin <= 14'(sink_th)) || (14'(climb_th) <= vin);
    endcase
    cls_next = cls;
    if (chg) begin
      if (vin <= 14'(sink_th)) cls_next = CLS_SINK;
      else if (14'(climb_th) <= vin) cls_next = CLS_CLIMB;
      else cls_next = CLS_SILENT;
    end
  end

  // multiply operands
  logic [12:0] lo_v, hi_v;
  logic signed [13:0] ma, mb;
  logic signed [27:0] prod_next;
  logic [12:0] span;
  always_comb begin
    case (fld)
      F_FREQ: begin lo_v = ea.freq; hi_v = re.freq; end
      F_PER:  begin lo_v = 13'(ea.period); hi_v = 13'(re.period); end
      F_DUTY: begin lo_v = 13'(ea.duty); hi_v = 13'(re.duty); end
      default: begin lo_v = '0; hi_v = '0; end
    endcase
    span = 13'(14'(re.vel) - 14'(ea.vel));
    if (fld == F_ONT) begin
      ma = 14'(pr);
      mb = 14'(du);
    end else begin
      ma = 14'(hi_v) - 14'(lo_v);
      mb = 14'(v_r) - 14'(ea.vel);
    end
    prod_next = 28'(ma) * 28'(mb);
  end

  logic signed [27:0] mag;
  always_comb begin
    mag = prod[27] ? -prod : prod;
    dreq.start = (st == S_DIVS) && (fld != F_ONT);
    dreq.num = mag[NUM_W-1:0];
    dreq.den = span;
  end

  // floor correction and on-time clamp
  logic [27:0] qa;
  logic signed [27:0] res;
  logic [12:0] val;
  logic [39:0] pct_prod;
  logic [13:0] pct_q;
  logic [11:0] on_sat;
  always_comb begin
    qa = {1'b0, drsp.quo} + 28'(prod[27] && (drsp.rem != '0));
    res = prod[27] ? -$signed(qa) : $signed(qa);
    val = 13'(res + $signed(28'(lo_v)));
    pct_prod = {20'd0, prod[19:0]} * {20'd0, PCT_RECIP};
    pct_q = pct_prod[PCT_SHIFT +: 14];
    on_sat = (pct_q > 14'd4095) ? 12'd4095 : pct_q[11:0];
  end

  logic step_done;
  assign step_done = drsp.done || (fld == F_ONT);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      cls <= CLS_SILENT;
      out_ch.valid <= 1'b0;
    end else begin
      if (st == S_DONE && (!out_ch.valid || out_ch.ready)) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (in_acc && in_ch.req_type == REQ_SAMPLE) begin
            cls <= cls_next;
            st <= (cls_next == CLS_SILENT) ? S_DONE : S_RD;
          end
        end
        S_RD: st <= S_CHK;
        S_CHK: begin
          if (v_r <= re.vel || idx == last) st <= S_MUL;
          else st <= S_RD;
        end
        S_MUL: st <= S_DIVS;
        S_DIVS: st <= S_DIVW;
        S_DIVW: begin
          if (step_done) st <= (fld == F_ONT) ? S_DONE : S_MUL;
        end
        S_DONE: begin
          if (!out_ch.valid || out_ch.ready) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      S_IDLE: begin
        v_r <= in_ch.velocity;
        idx <= '0;
      end
      S_CHK: begin
        if (v_r <= re.vel && idx != '0) begin
          fld <= F_FREQ;
        end else if (v_r <= re.vel || idx == last) begin
          fr <= re.freq;
          pr <= re.period;
          du <= re.duty;
          fld <= F_ONT;
        end else begin
          ea <= re;
          idx <= idx + 1'b1;
        end
      end
      S_MUL: prod <= prod_next;
      S_DIVW: begin
        if (step_done) begin
          case (fld)
            F_FREQ: fr <= val;
            F_PER:  pr <= val[11:0];
            F_DUTY: du <= val[6:0];
            default: begin
              if (pr == on_sat) begin
                pr <= '0;
                ot <= '0;
              end else begin
                ot <= on_sat;
              end
            end
          endcase
          fld <= fld + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_ch.valid || out_ch.ready) begin
          out_ch.beep_class <= cls;
          out_ch.tone_on <= (cls != CLS_SILENT);
          out_ch.tone_freq <= (cls != CLS_SILENT) ? fr : '0;
          out_ch.beep_period <= (cls != CLS_SILENT) ? pr : '0;
          out_ch.beep_on_time <= (cls != CLS_SILENT) ? ot : '0;
          out_ch.beep_volume <= (cls != CLS_SILENT) ? vol : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sink_th <= -12'sd300;
      climb_th <= 12'sd20;
      sens <= 10'd10;
      vol <= 7'd50;
      tsize <= 5'd12;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_SINK:  sink_th <= cfg_ch.data;
        REG_CLIMB: climb_th <= cfg_ch.data;
        REG_SENS:  sens <= cfg_ch.data[9:0];
        REG_VOL:   vol <= cfg_ch.data[6:0];
        REG_TSIZE: tsize <= cfg_ch.data[4:0];
        default: ;
      endcase
    end
  end

  `VTM_ASSERT_NOW(a_div_in_wait, drsp.done, st == S_DIVW)
  `VTM_ASSERT_NOW(a_walk_bound, st == S_CHK, idx <= last)
  `VTM_ASSERT_NOW(a_mute_zero, out_ch.valid && !out_ch.tone_on, out_ch.tone_freq == 13'd0 && out_ch.beep_period == 12'd0 && out_ch.beep_volume == 7'd0)
  `VTM_ASSERT_NEXT(a_sample_busy, in_acc && in_ch.req_type == REQ_SAMPLE, !in_ch.ready)
endmodule
`default_nettype wire

// ===== design/vtm_ram.sv =====
`default_nettype none
module vtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/vtm_div.sv =====
`default_nettype none
module vtm_div import vtm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire div_req_t req,
  output div_rsp_t rsp
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic busy;
  logic done;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0] rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0] rem_sh;
  logic fit;

  assign rem_sh = {rem[DEN_W-1:0], quo[NUM_W-1]};
  assign fit = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.num;
      rem <= '0;
      den <= req.den;
    end else if (busy) begin
      rem <= fit ? rem_sh - {1'b0, den} : rem_sh;
      quo <= {quo[NUM_W-2:0], fit};
    end
  end

  assign rsp = '{done: done, quo: quo, rem: rem[DEN_W-1:0]};
endmodule
`default_nettype wire
